FILE: rtl/gbns_pkg.sv
// Shared types and constants for the go-back-N sender window.
package gbns_pkg;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_MAX_WINDOW  = 32;

   localparam logic [1:0] ACT_QUEUE = 2'd0;
   localparam logic [1:0] ACT_ACK   = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic REG_WINDOW_SIZE   = 1'b0;
   localparam logic REG_TIMEOUT_TICKS = 1'b1;

   localparam logic [5:0]  RST_WINDOW_SIZE   = 6'd4;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_READ,
      ST_SEND,
      ST_NONE
   } gbns_state_type;

   typedef struct packed {
      logic accept;
      logic plan;
      logic read;
      logic send;
      logic none;
   } gbns_cmd_type;

   typedef struct packed {
      logic take_send;
      logic take_plan;
      logic plan_send;
      logic last_frame;
      logic out_free;
   } gbns_sts_type;

endpackage

FILE: rtl/gbns_ctrl.sv
// Sequencing state machine of the go-back-N sender window.
module gbns_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gbns_pkg::gbns_sts_type sts,
   output gbns_pkg::gbns_cmd_type cmd
);
   import gbns_pkg::*;

   gbns_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.take_send) begin
                  state_in = ST_READ;
               end else if (sts.take_plan) begin
                  state_in = ST_PLAN;
               end else begin
                  state_in = ST_NONE;
               end
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = sts.plan_send ? ST_READ : ST_NONE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.send = 1'b1;
               state_in = sts.last_frame ? ST_IDLE : ST_READ;
            end
         end
         ST_NONE: begin
            if (sts.out_free) begin
               cmd.none = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/gbns_dp.sv
// Datapath of the go-back-N sender window: pointers, tag memory, output word.
module gbns_dp #(
   parameter int QUEUE_DEPTH = gbns_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_WINDOW  = gbns_pkg::DEF_MAX_WINDOW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_action,
   input  logic [15:0]            req_message_tag,
   input  logic [5:0]             req_ack_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_frame_valid,
   output logic [5:0]             rsp_frame_seq,
   output logic [15:0]            rsp_frame_tag,
   output logic                   rsp_queue_full,
   output logic [6:0]             rsp_freed_count,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wr_data,
   input  gbns_pkg::gbns_cmd_type cmd,
   output gbns_pkg::gbns_sts_type sts
);
   import gbns_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
   localparam int CAP   = (MAX_WINDOW < QUEUE_DEPTH - 1) ? MAX_WINDOW : QUEUE_DEPTH - 1;

   function automatic logic [CW-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                               input logic [PTR_W-1:0] b);
      if (a >= b) begin
         return CW'(a) - CW'(b);
      end else begin
         return CW'(QUEUE_DEPTH) - (CW'(b) - CW'(a));
      end
   endfunction

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end else begin
         return p + PTR_W'(1);
      end
   endfunction

   logic [15:0] tag_mem [QUEUE_DEPTH];
   logic [15:0] rdata_ff;
   logic        mem_we;

   logic [PTR_W-1:0] nfs_ff, nfs_in;
   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [PTR_W-1:0] nts_ff, nts_in;
   logic [CNT_W-1:0] queued_ff, queued_in;
   logic [15:0]      idle_ff, idle_in;
   logic [5:0]       win_cfg_ff, win_cfg_in;
   logic [15:0]      tmo_ff, tmo_in;
   logic [CW-1:0]    remain_ff, remain_in;
   logic [CW-1:0]    freed_ff, freed_in;
   logic             full_ff, full_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             out_frame_valid_ff;
   logic [5:0]       out_seq_ff;
   logic [15:0]      out_tag_ff;
   logic             out_full_ff;
   logic [6:0]       out_freed_ff;
   logic             out_last_ff;

   logic [CW-1:0]    win_eff;
   logic [CW-1:0]    out_dist;
   logic [CW-1:0]    ack_dist;
   logic [PTR_W-1:0] ack_ptr;
   logic             ack_ok;
   logic [15:0]      idle_sat;
   logic [CW-1:0]    tick_n;
   logic [CW-1:0]    plan_room;
   logic [CW-1:0]    plan_win;
   logic [CW-1:0]    plan_min;
   logic [CW-1:0]    plan_count;
   logic             take_send;
   logic             take_plan;
   logic             out_free;

   assign win_eff  = (CW'(win_cfg_ff) > CW'(CAP)) ? CW'(CAP) : CW'(win_cfg_ff);
   assign ack_ptr  = PTR_W'(req_ack_number);
   assign ack_ok   = (QUEUE_DEPTH > 63) ? 1'b1 :
                     ({1'b0, req_ack_number} < 7'(QUEUE_DEPTH));
   assign out_dist = ring_dist(nts_ff, oldest_ff);
   assign ack_dist = ring_dist(ack_ptr, oldest_ff);
   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign tick_n   = (win_eff < CW'(queued_ff)) ? win_eff : CW'(queued_ff);

   // frames an ack may release: limited by freed, queued entries left, window room
   assign plan_room  = CW'(queued_ff) - out_dist;
   assign plan_win   = (win_eff > out_dist) ? win_eff - out_dist : '0;
   assign plan_min   = (plan_room < plan_win) ? plan_room : plan_win;
   assign plan_count = (freed_ff < plan_min) ? freed_ff : plan_min;

   // what the offered word would do, decoded ahead of the accept
   assign take_send = (req_action == ACT_QUEUE) ?
                         ((queued_ff != CNT_W'(QUEUE_DEPTH)) && (nts_ff == nfs_ff) &&
                          (out_dist < win_eff)) :
                      (req_action == ACT_TICK) ?
                         ((queued_ff != '0) && (idle_sat >= tmo_ff) && (tick_n != '0)) :
                      1'b0;
   assign take_plan = (req_action == ACT_ACK) && ack_ok && (ack_dist < out_dist);

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts.take_send  = take_send;
   assign sts.take_plan  = take_plan;
   assign sts.plan_send  = (plan_count != '0);
   assign sts.last_frame = (remain_ff == CW'(1));
   assign sts.out_free   = out_free;

   always_comb begin
      nfs_in     = nfs_ff;
      oldest_in  = oldest_ff;
      nts_in     = nts_ff;
      queued_in  = queued_ff;
      idle_in    = idle_ff;
      remain_in  = remain_ff;
      freed_in   = freed_ff;
      full_in    = full_ff;
      win_cfg_in = win_cfg_ff;
      tmo_in     = tmo_ff;
      mem_we     = 1'b0;

      if (cmd.accept) begin
         full_in  = 1'b0;
         freed_in = '0;
         unique case (req_action)
            ACT_QUEUE: begin
               if (queued_ff == CNT_W'(QUEUE_DEPTH)) begin
                  full_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  queued_in = queued_ff + CNT_W'(1);
                  nfs_in    = ring_inc(nfs_ff);
                  remain_in = CW'(1);
               end
            end
            ACT_ACK: begin
               if (ack_ok && (ack_dist < out_dist)) begin
                  freed_in  = ack_dist + CW'(1);
                  queued_in = queued_ff - CNT_W'(ack_dist + CW'(1));
                  oldest_in = ring_inc(ack_ptr);
               end
            end
            ACT_TICK: begin
               if (queued_ff != '0) begin
                  idle_in = idle_sat;
                  if ((idle_sat >= tmo_ff) && (tick_n != '0)) begin
                     nts_in    = oldest_ff;
                     remain_in = tick_n;
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.plan) begin
         remain_in = plan_count;
      end

      if (cmd.send) begin
         nts_in    = ring_inc(nts_ff);
         remain_in = remain_ff - CW'(1);
         idle_in   = '0;
      end

      if (csr_wr_en) begin
         if (csr_index == REG_WINDOW_SIZE) begin
            win_cfg_in = csr_wr_data[5:0];
         end else begin
            tmo_in = csr_wr_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.send || cmd.none) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nfs_ff       <= '0;
         oldest_ff    <= '0;
         nts_ff       <= '0;
         queued_ff    <= '0;
         idle_ff      <= '0;
         remain_ff    <= '0;
         win_cfg_ff   <= RST_WINDOW_SIZE;
         tmo_ff       <= RST_TIMEOUT_TICKS;
         rsp_valid_ff <= 1'b0;
      end else begin
         nfs_ff       <= nfs_in;
         oldest_ff    <= oldest_in;
         nts_ff       <= nts_in;
         queued_ff    <= queued_in;
         idle_ff      <= idle_in;
         remain_ff    <= remain_in;
         win_cfg_ff   <= win_cfg_in;
         tmo_ff       <= tmo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freed_ff <= freed_in;
      full_ff  <= full_in;
      if (cmd.send) begin
         out_frame_valid_ff <= 1'b1;
         out_seq_ff         <= 6'(nts_ff);
         out_tag_ff         <= rdata_ff;
         out_full_ff        <= 1'b0;
         out_freed_ff       <= 7'(freed_ff);
         out_last_ff        <= sts.last_frame;
      end else if (cmd.none) begin
         out_frame_valid_ff <= 1'b0;
         out_seq_ff         <= '0;
         out_tag_ff         <= '0;
         out_full_ff        <= full_ff;
         out_freed_ff       <= 7'(freed_ff);
         out_last_ff        <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[nfs_ff] <= req_message_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rdata_ff <= tag_mem[nts_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_valid = out_frame_valid_ff;
   assign rsp_frame_seq   = out_seq_ff;
   assign rsp_frame_tag   = out_tag_ff;
   assign rsp_queue_full  = out_full_ff;
   assign rsp_freed_count = out_freed_ff;
   assign rsp_last        = out_last_ff;

endmodule

FILE: rtl/go_back_n_sender_window.sv
// Top level of the go-back-N sender window.
// A word that sends no frame loads its result from the NONE state; an ack that frees
// entries passes through PLAN first. Each frame is a tag memory read (READ), then an
// output load (SEND) that waits while the previous output word is still unread.
// The next word is accepted the cycle after the last result is loaded.
// Reset is synchronous; the tag memory is not cleared and needs no sweep.
module go_back_n_sender_window #(
   parameter int QUEUE_DEPTH = gbns_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_WINDOW  = gbns_pkg::DEF_MAX_WINDOW
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_message_tag,
   input  logic [5:0]  req_ack_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_valid,
   output logic [5:0]  rsp_frame_seq,
   output logic [15:0] rsp_frame_tag,
   output logic        rsp_queue_full,
   output logic [6:0]  rsp_freed_count,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);
   import gbns_pkg::*;

   gbns_cmd_type cmd;
   gbns_sts_type sts;

   gbns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbns_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_message_tag (req_message_tag),
      .req_ack_number  (req_ack_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_frame_seq   (rsp_frame_seq),
      .rsp_frame_tag   (rsp_frame_tag),
      .rsp_queue_full  (rsp_queue_full),
      .rsp_freed_count (rsp_freed_count),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .sts             (sts)
   );

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("word accepted while previous one in progress");

   a_frame_not_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_valid) |-> !rsp_queue_full)
      else $error("frame result flagged queue full");

   a_no_frame_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_valid) |-> (rsp_last && rsp_frame_seq == 6'd0
                                           && rsp_frame_tag == 16'd0))
      else $error("no-frame result malformed");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.send || cmd.none) |-> (!rsp_valid || rsp_ready))
      else $error("output word overwritten");

endmodule

FILE: dv/go_back_n_sender_window_tb.sv
// Self-checking testbench for the go-back-N sender window, with its own window model.
module go_back_n_sender_window_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbns_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int DEPTH   = DEF_QUEUE_DEPTH;
   localparam int MAX_WIN = DEF_MAX_WINDOW;

   typedef struct packed {
      logic        frame_valid;
      logic [5:0]  frame_seq;
      logic [15:0] frame_tag;
      logic        queue_full;
      logic [6:0]  freed_count;
      logic        last;
   } frame_type;

   class sender_window_model;
      logic [5:0]  window_reg;
      logic [15:0] timeout_reg;
      logic [15:0] tag_mem [DEPTH];
      bit          held [DEPTH];
      logic [5:0]  next_free;
      logic [5:0]  oldest;
      logic [5:0]  next_send;
      logic [6:0]  queued;
      logic [15:0] idle_count;
      int          sent_now;
      frame_type   frames_due [$];
      int          mismatches;
      int          frames_seen;

      function new();
         window_reg  = RST_WINDOW_SIZE;
         timeout_reg = RST_TIMEOUT_TICKS;
         foreach (held[i]) held[i] = 0;
         next_free   = 0;
         oldest      = 0;
         next_send   = 0;
         queued      = 0;
         idle_count  = 0;
         mismatches  = 0;
         frames_seen = 0;
      endfunction

      function void set_regs(logic [5:0] win, logic [15:0] tmo);
         window_reg  = win;
         timeout_reg = tmo;
      endfunction

      function int active_window();
         int w;
         w = window_reg;
         if (w > MAX_WIN) w = MAX_WIN;
         if (w > DEPTH - 1) w = DEPTH - 1;
         return w;
      endfunction

      function logic [5:0] ring_gap(logic [5:0] a, logic [5:0] b);
         return a - b;
      endfunction

      function void push_frame(bit fv, logic [5:0] seq, logic [15:0] tag, bit full,
                               logic [6:0] freed);
         frame_type f;
         f.frame_valid = fv;
         f.frame_seq   = seq;
         f.frame_tag   = tag;
         f.queue_full  = full;
         f.freed_count = freed;
         f.last        = 0;
         frames_due.push_back(f);
         sent_now++;
      endfunction

      function void send_frame(logic [6:0] freed);
         push_frame(1, next_send, tag_mem[next_send], 0, freed);
         next_send++;
         idle_count = 0;
      endfunction

      function void apply_word(logic [1:0] act, logic [15:0] tag, logic [5:0] ack);
         int         win;
         int         n;
         logic [6:0] freed;
         logic [5:0] span;
         logic [5:0] s;
         win      = active_window();
         freed    = 0;
         sent_now = 0;
         case (act)
            ACT_QUEUE: begin
               if (queued == 7'(DEPTH)) begin
                  push_frame(0, 0, 0, 1, 0);
               end else begin
                  s = next_free;
                  tag_mem[s] = tag;
                  held[s] = 1;
                  queued++;
                  next_free = s + 6'd1;
                  if (next_send == s && ring_gap(next_send, oldest) < win) send_frame(0);
               end
            end
            ACT_ACK: begin
               span = ring_gap(ack, oldest);
               if (span < ring_gap(next_send, oldest)) begin
                  freed = 7'(span) + 7'd1;
                  for (int i = 0; i < freed; i++) held[oldest + 6'(i)] = 0;
                  queued = queued - freed;
                  oldest = ack + 6'd1;
                  for (int i = 0; i < freed; i++) begin
                     if (!held[next_send] || ring_gap(next_send, oldest) >= win) break;
                     send_frame(freed);
                  end
               end
            end
            ACT_TICK: begin
               if (queued != 0) begin
                  if (idle_count != 16'hFFFF) idle_count++;
                  if (idle_count >= timeout_reg) begin
                     n = (win < queued) ? win : queued;
                     if (n > 0) begin
                        next_send = oldest;
                        repeat (n) send_frame(0);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         if (sent_now == 0) push_frame(0, 0, 0, 0, freed);
         frames_due[frames_due.size() - 1].last = 1;
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         mismatches++;
      endtask

      task match_frame(frame_type got);
         frame_type want;
         string     bad;
         frames_seen++;
         if (frames_due.size() == 0) begin
            report($sformatf("word %0d arrived with none expected: %p", frames_seen, got));
            return;
         end
         want = frames_due.pop_front();
         bad = "";
         if (got.frame_valid !== want.frame_valid) bad = {bad, " frame_valid"};
         if (got.frame_seq !== want.frame_seq) bad = {bad, " frame_seq"};
         if (got.frame_tag !== want.frame_tag) bad = {bad, " frame_tag"};
         if (got.queue_full !== want.queue_full) bad = {bad, " queue_full"};
         if (got.freed_count !== want.freed_count) bad = {bad, " freed_count"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "")
            report($sformatf("word %0d bad%s: got %p want %p", frames_seen, bad, got, want));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [15:0] req_message_tag;
   logic [5:0]  req_ack_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_frame_valid;
   logic [5:0]  rsp_frame_seq;
   logic [15:0] rsp_frame_tag;
   logic        rsp_queue_full;
   logic [6:0]  rsp_freed_count;
   logic        rsp_last;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wr_data;

   sender_window_model window_model = new();
   bit quiet = 0;
   bit hold_request = 0;

   go_back_n_sender_window dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_message_tag (req_message_tag),
      .req_ack_number  (req_ack_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_frame_seq   (rsp_frame_seq),
      .rsp_frame_tag   (rsp_frame_tag),
      .rsp_queue_full  (rsp_queue_full),
      .rsp_freed_count (rsp_freed_count),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int idle_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         window_model.match_frame({rsp_frame_valid, rsp_frame_seq, rsp_frame_tag,
                                   rsp_queue_full, rsp_freed_count, rsp_last});
   end

   // receiver: random stalls, plus one long hold to back up the block
   initial begin
      int n;
      rsp_ready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_request = 0;
         end else begin
            n = idle_gap();
            if (n > 0) begin
               rsp_ready <= 0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [1:0] act, logic [15:0] tag, logic [5:0] ack);
      int gap;
      req_valid       <= 1;
      req_action      <= act;
      req_message_tag <= tag;
      req_ack_number  <= ack;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      window_model.apply_word(act, tag, ack);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 0;
      while (window_model.frames_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_mode(logic [5:0] win, logic [15:0] tmo);
      csr_wr_en   <= 1;
      csr_index   <= REG_WINDOW_SIZE;
      csr_wr_data <= 16'(win);
      @(posedge clock);
      csr_index   <= REG_TIMEOUT_TICKS;
      csr_wr_data <= tmo;
      @(posedge clock);
      csr_wr_en <= 0;
      window_model.set_regs(win, tmo);
   endtask

   // mostly in-range acks so the window keeps moving; some stray ones and noise
   task automatic random_words(int count);
      logic [5:0] outstanding;
      int         r;
      repeat (count) begin
         outstanding = window_model.next_send - window_model.oldest;
         r = $urandom_range(0, 99);
         if (r < 40 && window_model.queued < 60) begin
            send_word(ACT_QUEUE, 16'($urandom), 6'($urandom));
         end else if (r < 75) begin
            if (outstanding != 0 && $urandom_range(0, 9) < 8)
               send_word(ACT_ACK, 16'($urandom),
                         window_model.oldest + 6'($urandom_range(0, outstanding - 1)));
            else
               send_word(ACT_ACK, 16'($urandom), 6'($urandom));
         end else if (r < 95) begin
            send_word(ACT_TICK, 16'($urandom), 6'($urandom));
         end else begin
            send_word(ACT_NONE, 16'($urandom), 6'($urandom));
         end
      end
   endtask

   initial begin
      reset           <= 1;
      req_valid       <= 0;
      req_action      <= ACT_TICK;
      req_message_tag <= 0;
      req_ack_number  <= 0;
      csr_wr_en       <= 0;
      csr_index       <= REG_WINDOW_SIZE;
      csr_wr_data     <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default window: fill it, leave one waiting, stray and real acks
      quiet = 1;
      send_word(ACT_QUEUE, 16'h0000, 6'd0);
      send_word(ACT_QUEUE, 16'hFFFF, 6'd63);
      send_word(ACT_QUEUE, 16'h5555, 6'd0);
      send_word(ACT_QUEUE, 16'hAAAA, 6'd0);
      send_word(ACT_QUEUE, 16'h1234, 6'd0);
      send_word(ACT_ACK, 16'hFFFF, 6'd63);
      send_word(ACT_ACK, 16'h0000, 6'd0);
      send_word(ACT_ACK, 16'h0000, 6'd4);
      send_word(ACT_ACK, 16'h0000, 6'd4);
      send_word(ACT_TICK, 16'h0000, 6'd0);
      send_word(ACT_NONE, 16'hFFFF, 6'd63);
      send_word(ACT_QUEUE, 16'h00FF, 6'd0);
      quiet = 0;

      // zero timeout resends the window
      settle();
      set_mode(6'd2, 16'd0);
      send_word(ACT_QUEUE, 16'h0F0F, 6'd0);
      send_word(ACT_QUEUE, 16'hF0F0, 6'd0);
      send_word(ACT_TICK, 16'h0000, 6'd0);
      send_word(ACT_ACK, 16'h0000, 6'd5);

      // shrink to zero: nothing goes out, ticks keep counting
      settle();
      set_mode(6'd0, 16'd1);
      send_word(ACT_QUEUE, 16'h3C3C, 6'd0);
      send_word(ACT_TICK, 16'h0000, 6'd0);
      send_word(ACT_ACK, 16'h0000, 6'd7);

      settle();
      set_mode(6'd1, 16'd1);
      send_word(ACT_TICK, 16'h0000, 6'd0);
      send_word(ACT_ACK, 16'h0000, 6'd8);

      settle();
      set_mode(6'd32, 16'd20);
      hold_request = 1;
      random_words(25);

      settle();
      set_mode(6'd1, 16'd3);
      quiet = 1;
      random_words(25);
      quiet = 0;

      settle();
      set_mode(6'd8, 16'd0);
      random_words(25);

      settle();
      set_mode(6'd31, 16'd7);
      quiet = 1;
      random_words(25);
      quiet = 0;

      settle();
      set_mode(6'd3, 16'd2);
      random_words(25);

      // closed window: fill the queue past full, then tick with nothing allowed out
      settle();
      set_mode(6'd0, 16'hFFFF);
      repeat (70) send_word(ACT_QUEUE, 16'($urandom), 6'($urandom));
      quiet = 1;
      repeat (10) send_word(ACT_TICK, 16'($urandom), 6'($urandom));
      quiet = 0;

      settle();
      set_mode(6'd32, 16'hFFFF);
      send_word(ACT_TICK, 16'h0000, 6'd0);

      settle();
      set_mode(6'd16, 16'd0);
      random_words(20);

      settle();
      set_mode(RST_WINDOW_SIZE, RST_TIMEOUT_TICKS);
      random_words(15);

      settle();
      if (window_model.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
